[hw/rtl/pic_pkg.sv]
package pic_pkg;

  localparam int MAX_PARTICLES_DEFAULT = 1024;
  localparam logic [31:0] MIN_LIFE = 32'd655;

  localparam logic CMD_SPAWN = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [2:0] REG_ACCEL_X    = 3'd0;
  localparam logic [2:0] REG_ACCEL_Y    = 3'd1;
  localparam logic [2:0] REG_ACCEL_Z    = 3'd2;
  localparam logic [2:0] REG_TURBULENCE = 3'd3;
  localparam logic [2:0] REG_CAP_LIMIT  = 3'd4;

  localparam logic [31:0] ACCEL_X_RST    = 32'd0;
  localparam logic [31:0] ACCEL_Y_RST    = 32'hFFF6_3333;
  localparam logic [31:0] ACCEL_Z_RST    = 32'd0;
  localparam logic [31:0] TURBULENCE_RST = 32'd0;
  localparam logic [10:0] CAP_LIMIT_RST  = 11'd1024;

  typedef struct packed {
    logic               command;
    logic signed [31:0] spawn_pos_x;
    logic signed [31:0] spawn_pos_y;
    logic signed [31:0] spawn_pos_z;
    logic signed [31:0] spawn_vel_x;
    logic signed [31:0] spawn_vel_y;
    logic signed [31:0] spawn_vel_z;
    logic [30:0]        spawn_life;
    logic [30:0]        spawn_size;
    logic [30:0]        tick_step;
  } cmd_t;

  typedef struct packed {
    logic [10:0]        alive_count;
    logic               spawn_accepted;
    logic               bounds_valid;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
    logic [30:0]        largest_size;
  } res_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] life;
    logic [30:0]        size;
  } part_t;

endpackage

[hw/rtl/pic_ram.sv]
module pic_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hw/rtl/pic_macu.sv]
module pic_macu (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] c_i,
  output logic signed [31:0] r_o
);

  logic signed [63:0] prod;

  assign prod = a_i * b_i;

  always_ff @(posedge clk_i) begin
    r_o <= c_i + prod[47:16];
  end

endmodule

[hw/rtl/particle_integrate_compact_unit.sv]
// Particle table with semi-implicit Euler integration and compaction.
// Command channel: an item transfers when start is high and busy is low.
//   command 0 spawns a particle at the end of the table (dropped when the
//   table holds min(capacity_limit, MaxParticles) particles); command 1
//   advances every live particle by tick_step, removes dead ones and
//   reports the bounding box, largest size and live count.
// Result channel: done_o is high for one cycle with res_o; it cannot stall.
// Config channel: cfg_ready_o is always high; a write transfers on
//   cfg_valid_i. Write only while busy is low and no result is pending.
// Timing: a spawn, or a tick on an empty table, returns its result in the
//   cycle after the transfer and busy never rises. In a tick each live
//   particle makes one read of the particle RAM, a write only if it is
//   still alive, and eight multiply-adds through the single shared
//   multiply-accumulate unit.
// Reset: the live count clears and the registers take their reset values;
//   the particle RAM is not cleared, since only written entries are read.
module particle_integrate_compact_unit #(
  parameter int MaxParticles = pic_pkg::MAX_PARTICLES_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pic_pkg::cmd_t cmd_i,
  output logic          done_o,
  output pic_pkg::res_t res_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  localparam int CntW  = $clog2(MaxParticles + 1);
  localparam int AddrW = (MaxParticles > 1) ? $clog2(MaxParticles) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_LOAD  = 6'b000100,
    S_CALC  = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0] cnt_q, rd_q, wr_q;
  logic [3:0]      step_q;
  logic [31:0]     dt_q;
  logic [31:0]     accel_x_q, accel_y_q, accel_z_q, turb_q;
  logic [10:0]     limit_q;

  logic signed [31:0] px_q, py_q, pz_q, vx_q, vy_q, vz_q, ax_q, az_q, life_q;
  logic [30:0]        size_q;
  logic signed [31:0] mnx_q, mny_q, mnz_q, mxx_q, mxy_q, mxz_q;
  logic [30:0]        msz_q;

  logic          done_q;
  pic_pkg::res_t res_q;

  logic accept, is_spawn, room, alive, last;
  logic [31:0] spawn_life;
  logic signed [31:0] mac_a, mac_b, mac_c, mac_r;
  pic_pkg::part_t ram_wdata, ram_rdata;
  logic ram_we;
  logic [AddrW-1:0] ram_waddr;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign res_o       = res_q;

  assign accept   = start && !busy;
  assign is_spawn = (cmd_i.command == pic_pkg::CMD_SPAWN);
  assign room     = (32'(cnt_q) < 32'(limit_q)) && (32'(cnt_q) < 32'(MaxParticles));
  assign alive    = (life_q > 32'sd0);
  assign last     = ((rd_q + CntW'(1)) == cnt_q);

  assign spawn_life = ({1'b0, cmd_i.spawn_life} < pic_pkg::MIN_LIFE) ?
                      pic_pkg::MIN_LIFE : {1'b0, cmd_i.spawn_life};

  always_comb begin
    if (state_q == S_IDLE) begin
      ram_we    = accept && is_spawn && room;
      ram_waddr = cnt_q[AddrW-1:0];
      ram_wdata = '{pos_x: cmd_i.spawn_pos_x, pos_y: cmd_i.spawn_pos_y,
                    pos_z: cmd_i.spawn_pos_z, vel_x: cmd_i.spawn_vel_x,
                    vel_y: cmd_i.spawn_vel_y, vel_z: cmd_i.spawn_vel_z,
                    life: spawn_life, size: cmd_i.spawn_size};
    end else begin
      ram_we    = (state_q == S_WRITE) && alive;
      ram_waddr = wr_q[AddrW-1:0];
      ram_wdata = '{pos_x: px_q, pos_y: py_q, pos_z: pz_q, vel_x: vx_q,
                    vel_y: vy_q, vel_z: vz_q, life: life_q, size: size_q};
    end
  end

  pic_ram #(
    .Width($bits(pic_pkg::part_t)),
    .Depth(MaxParticles)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    case (step_q)
      4'd0:    begin mac_a = turb_q;    mac_b = 32'sd0 - vz_q; mac_c = accel_x_q; end
      4'd1:    begin mac_a = turb_q;    mac_b = vx_q;          mac_c = accel_z_q; end
      4'd2:    begin mac_a = ax_q;      mac_b = dt_q;          mac_c = vx_q;      end
      4'd3:    begin mac_a = accel_y_q; mac_b = dt_q;          mac_c = vy_q;      end
      4'd4:    begin mac_a = az_q;      mac_b = dt_q;          mac_c = vz_q;      end
      4'd5:    begin mac_a = vx_q;      mac_b = dt_q;          mac_c = px_q;      end
      4'd6:    begin mac_a = vy_q;      mac_b = dt_q;          mac_c = py_q;      end
      4'd7:    begin mac_a = vz_q;      mac_b = dt_q;          mac_c = pz_q;      end
      default: begin mac_a = '0;        mac_b = '0;            mac_c = '0;        end
    endcase
  end

  pic_macu u_macu (
    .clk_i (clk_i),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .c_i   (mac_c),
    .r_o   (mac_r)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept && !is_spawn && (cnt_q != '0)) state_d = S_READ;
      S_READ:  state_d = S_LOAD;
      S_LOAD:  state_d = S_CALC;
      S_CALC:  if (step_q == 4'd8) state_d = S_WRITE;
      S_WRITE: state_d = last ? S_DONE : S_READ;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rd_q      <= '0;
      wr_q      <= '0;
      step_q    <= '0;
      done_q    <= 1'b0;
      accel_x_q <= pic_pkg::ACCEL_X_RST;
      accel_y_q <= pic_pkg::ACCEL_Y_RST;
      accel_z_q <= pic_pkg::ACCEL_Z_RST;
      turb_q    <= pic_pkg::TURBULENCE_RST;
      limit_q   <= pic_pkg::CAP_LIMIT_RST;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          pic_pkg::REG_ACCEL_X:    accel_x_q <= cfg_data_i;
          pic_pkg::REG_ACCEL_Y:    accel_y_q <= cfg_data_i;
          pic_pkg::REG_ACCEL_Z:    accel_z_q <= cfg_data_i;
          pic_pkg::REG_TURBULENCE: turb_q    <= cfg_data_i;
          pic_pkg::REG_CAP_LIMIT:  limit_q   <= cfg_data_i[10:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          rd_q <= '0;
          wr_q <= '0;
          if (accept) begin
            if (is_spawn && room) cnt_q <= cnt_q + CntW'(1);
            if (is_spawn || (cnt_q == '0)) done_q <= 1'b1;
          end
        end
        S_LOAD:  step_q <= '0;
        S_CALC:  step_q <= step_q + 4'd1;
        S_WRITE: begin
          rd_q <= rd_q + CntW'(1);
          if (alive) wr_q <= wr_q + CntW'(1);
        end
        S_DONE: begin
          cnt_q  <= wr_q;
          done_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          dt_q                 <= {1'b0, cmd_i.tick_step};
          res_q                <= '0;
          res_q.alive_count    <= 11'(cnt_q + CntW'(is_spawn && room));
          res_q.spawn_accepted <= is_spawn && room;
        end
      end
      S_LOAD: begin
        px_q   <= ram_rdata.pos_x;
        py_q   <= ram_rdata.pos_y;
        pz_q   <= ram_rdata.pos_z;
        vx_q   <= ram_rdata.vel_x;
        vy_q   <= ram_rdata.vel_y;
        vz_q   <= ram_rdata.vel_z;
        life_q <= ram_rdata.life - dt_q;
        size_q <= ram_rdata.size;
      end
      S_CALC: begin
        case (step_q)
          4'd1: ax_q <= mac_r;
          4'd2: az_q <= mac_r;
          4'd3: vx_q <= mac_r;
          4'd4: vy_q <= mac_r;
          4'd5: vz_q <= mac_r;
          4'd6: px_q <= mac_r;
          4'd7: py_q <= mac_r;
          4'd8: pz_q <= mac_r;
          default: ;
        endcase
      end
      S_WRITE: begin
        if (alive) begin
          if (wr_q == '0) begin
            mnx_q <= px_q; mxx_q <= px_q;
            mny_q <= py_q; mxy_q <= py_q;
            mnz_q <= pz_q; mxz_q <= pz_q;
            msz_q <= size_q;
          end else begin
            if (px_q < mnx_q) mnx_q <= px_q;
            if (px_q > mxx_q) mxx_q <= px_q;
            if (py_q < mny_q) mny_q <= py_q;
            if (py_q > mxy_q) mxy_q <= py_q;
            if (pz_q < mnz_q) mnz_q <= pz_q;
            if (pz_q > mxz_q) mxz_q <= pz_q;
            if (size_q > msz_q) msz_q <= size_q;
          end
        end
      end
      S_DONE: begin
        res_q <= '0;
        res_q.alive_count <= 11'(wr_q);
        if (wr_q != '0) begin
          res_q.bounds_valid <= 1'b1;
          res_q.min_x        <= mnx_q;
          res_q.min_y        <= mny_q;
          res_q.min_z        <= mnz_q;
          res_q.max_x        <= mxx_q;
          res_q.max_y        <= mxy_q;
          res_q.max_z        <= mxz_q;
          res_q.largest_size <= msz_q;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(MaxParticles)) else $error("live count above table size");

  a_wr_le_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (wr_q <= rd_q)) else $error("compaction write passed read");

  a_spawn_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_spawn) |=> (done_o && !busy)) else $error("spawn result missing");

  a_tick_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> (done_o && (32'(cnt_q) == 32'($past(wr_q)))))
    else $error("tick count mismatch");
`endif

endmodule
